FILE: rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// Used by rgbhsv_prep, rgbhsv_cell and rgb_to_hsv_unit; no dependencies.
package rgbhsv_pkg;

  localparam int CHAN_W = 8;
  localparam int REM_W  = 11;
  localparam int LANES  = 3;

  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;
  localparam int LANE_BRI = 2;

  localparam logic [REM_W-1:0] BRI_DIV = REM_W'(255);

  typedef logic [REM_W-1:0] rem_t;

  typedef struct packed {
    rem_t rem;
    rem_t dvs;
  } div_lane_t;

endpackage

FILE: rtl/rgbhsv_prep.sv
// Front stage: max/min, channel spread, hue numerator and first quotient bit
// for the hue, saturation and brightness divide lanes. Uses rgbhsv_pkg.
module rgbhsv_prep import rgbhsv_pkg::*; #(
  parameter int QW = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output logic              valid_o,
  input  logic              ready_i,
  output div_lane_t         lane_o [LANES],
  output logic [QW-1:0]     quo_o [LANES]
);

  logic              valid_r;
  logic              adv;
  logic [CHAN_W-1:0] mx, mn, d;
  rem_t              r11, g11, b11, d11, six_d, num;
  rem_t              n_v  [LANES];
  rem_t              dv_v [LANES];
  div_lane_t         lane_nxt [LANES];
  logic [QW-1:0]     quo_nxt [LANES];
  div_lane_t         lane_r [LANES];
  logic [QW-1:0]     quo_r [LANES];

  assign adv     = !valid_r || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_r;
  assign lane_o  = lane_r;
  assign quo_o   = quo_r;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    d     = mx - mn;
    r11   = REM_W'(red_i);
    g11   = REM_W'(green_i);
    b11   = REM_W'(blue_i);
    d11   = REM_W'(d);
    six_d = (d11 << 2) + (d11 << 1);
    if (red_i == mx) begin
      if (green_i >= blue_i) num = g11 - b11;
      else num = six_d - (b11 - g11);
    end else if (green_i == mx) begin
      num = (d11 << 1) + b11 - r11;
    end else begin
      num = (d11 << 2) + r11 - g11;
    end
    // zero spread or black: 0 / 1 gives a zero quotient
    n_v[LANE_HUE]  = (d == '0) ? '0 : num;
    dv_v[LANE_HUE] = (d == '0) ? REM_W'(1) : six_d;
    n_v[LANE_SAT]  = d11;
    dv_v[LANE_SAT] = (mx == '0) ? REM_W'(1) : REM_W'(mx);
    n_v[LANE_BRI]  = REM_W'(mx);
    dv_v[LANE_BRI] = BRI_DIV;
    for (int i = 0; i < LANES; i++) begin
      lane_nxt[i].dvs = dv_v[i];
      lane_nxt[i].rem = (n_v[i] >= dv_v[i]) ? (n_v[i] - dv_v[i]) : n_v[i];
      quo_nxt[i]      = QW'(n_v[i] >= dv_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      lane_r <= lane_nxt;
      quo_r  <= quo_nxt;
    end
  end

endmodule

FILE: rtl/rgbhsv_cell.sv
// One restoring-division cell: shifts one quotient bit into each of the
// three lanes and hands the partial remainders on. Uses rgbhsv_pkg.
module rgbhsv_cell import rgbhsv_pkg::*; #(
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  div_lane_t     lane_i [LANES],
  input  logic [QW-1:0] quo_i [LANES],
  output logic          valid_o,
  input  logic          ready_i,
  output div_lane_t     lane_o [LANES],
  output logic [QW-1:0] quo_o [LANES]
);

  logic            valid_r;
  logic            adv;
  logic [REM_W:0]  dbl [LANES];
  logic [REM_W:0]  dvx [LANES];
  logic            ge  [LANES];
  div_lane_t       lane_nxt [LANES];
  logic [QW-1:0]   quo_nxt [LANES];
  div_lane_t       lane_r [LANES];
  logic [QW-1:0]   quo_r [LANES];

  assign adv     = !valid_r || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_r;
  assign lane_o  = lane_r;
  assign quo_o   = quo_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dbl[i] = {lane_i[i].rem, 1'b0};
      dvx[i] = {1'b0, lane_i[i].dvs};
      ge[i]  = dbl[i] >= dvx[i];
      lane_nxt[i].dvs = lane_i[i].dvs;
      lane_nxt[i].rem = ge[i] ? REM_W'(dbl[i] - dvx[i]) : REM_W'(dbl[i]);
      quo_nxt[i]      = {quo_i[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      lane_r <= lane_nxt;
      quo_r  <= quo_nxt;
    end
  end

endmodule

FILE: rtl/rgb_to_hsv_unit.sv
// RGB to HSV converter top level: front stage plus a chain of division cells.
// Depends on rgbhsv_pkg, rgbhsv_prep and rgbhsv_cell.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata: red, green, blue,
//   8 bits each. Result words leave on out_tvalid/out_tready/out_tdata:
//   hue, saturation, brightness, FRAC_BITS+1 bits each, as fractions of
//   2^FRAC_BITS truncated toward zero.
//   A word is taken at each edge where tvalid and tready are both high.
//   The pipeline is one front stage, then FRAC_BITS cells.
//   Throughput is one word per cycle while out_tready stays high.
//   Each cell resolves one quotient bit of all three divides and passes
//   its remainders on, so the cell chain length sets the latency.
//   Every stage has its own valid bit and takes a new word when it is
//   empty or its neighbor takes its word, so bubbles close up while the
//   receiver stalls; once all stages are full, in_tready drops.
//   Synchronous reset empties every stage; no word is lost or repeated
//   across a stall.
module rgb_to_hsv_unit import rgbhsv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic [3*CHAN_W-1:0]                    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // hue_out, sat_out, bright_out, each FRAC_BITS+1 bits from bit 0 up; zero pad
  output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]   out_tdata
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = ((3*QW+7)/8)*8;
  localparam logic [QW-1:0] ONE_FIX = QW'(1) << FRAC_BITS;

  logic          vld_s  [FRAC_BITS+1];
  logic          rdy_s  [FRAC_BITS+1];
  div_lane_t     lane_s [FRAC_BITS+1][LANES];
  logic [QW-1:0] quo_s  [FRAC_BITS+1][LANES];
  logic [QW-1:0] hue_q, sat_q, bri_q;

  rgbhsv_prep #(.QW(QW)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .red_i   (in_tdata[CHAN_W-1:0]),
    .green_i (in_tdata[2*CHAN_W-1:CHAN_W]),
    .blue_i  (in_tdata[3*CHAN_W-1:2*CHAN_W]),
    .valid_o (vld_s[0]),
    .ready_i (rdy_s[0]),
    .lane_o  (lane_s[0]),
    .quo_o   (quo_s[0])
  );

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_cell
    rgbhsv_cell #(.QW(QW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld_s[k-1]),
      .ready_o (rdy_s[k-1]),
      .lane_i  (lane_s[k-1]),
      .quo_i   (quo_s[k-1]),
      .valid_o (vld_s[k]),
      .ready_i (rdy_s[k]),
      .lane_o  (lane_s[k]),
      .quo_o   (quo_s[k])
    );
  end

  assign rdy_s[FRAC_BITS] = out_tready;
  assign out_tvalid       = vld_s[FRAC_BITS];
  assign hue_q            = quo_s[FRAC_BITS][LANE_HUE];
  assign sat_q            = quo_s[FRAC_BITS][LANE_SAT];
  assign bri_q            = quo_s[FRAC_BITS][LANE_BRI];
  assign out_tdata        = DW'({bri_q, sat_q, hue_q});

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hue_q < ONE_FIX)
    else $error("hue at or above one full turn");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sat_q <= ONE_FIX)
    else $error("saturation above one");

  a_bri_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> bri_q <= ONE_FIX)
    else $error("brightness above one");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sat_q == '0 |-> hue_q == '0)
    else $error("nonzero hue on a grey pixel");

endmodule
